// ===== hw/rtl/tpsu_pkg.sv =====
`timescale 1ns / 1ps
package tpsu_pkg;

  localparam int WordBits = 64;
  localparam int NumLanes = 6;
  localparam int MulStages = 2 * WordBits;

  localparam int LaneCum = 0;
  localparam int LaneRnd = 1;
  localparam int LanePoly = 2;
  localparam int LaneShare = 3;
  localparam int LaneLpc = 4;
  localparam int LaneKey = 5;

  typedef logic [WordBits-1:0] word_t;
  // modulus with one extra bit: a programmed zero stands for 2^WordBits
  typedef logic [WordBits:0] modw_t;

  typedef enum logic {
    OpUpdate   = 1'b0,
    OpValidate = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    RegPrime    = 3'd0,
    RegShare    = 3'd1,
    RegLagrange = 3'd2,
    RegPoly     = 3'd3,
    RegKey      = 3'd4,
    RegUpdEn    = 3'd5,
    RegVerEn    = 3'd6
  } reg_e;

  typedef struct packed {
    op_e                    op;
    word_t [NumLanes-1:0]   raw;
    word_t [NumLanes-1:0]   rem;
  } red_t;

  typedef struct packed {
    op_e   op;
    logic  ok;
    word_t cum;
    word_t t;
    word_t share;
    word_t lpc;
  } add_t;

  typedef struct packed {
    op_e   op;
    logic  ok;
    word_t cum;
    word_t x;
    word_t y;
    word_t acc;
  } mul_t;

  typedef struct packed {
    word_t cum;
    logic  ok;
  } res_t;

  // one restoring division step: remainder stays below m
  function automatic word_t div_step(word_t r, logic b, modw_t m);
    modw_t s;
    s = {r, b};
    if (s >= m) begin
      s = s - m;
    end
    return s[WordBits-1:0];
  endfunction

  // (a + b) mod m for a, b below m
  function automatic word_t mod_add(word_t a, word_t b, modw_t m);
    modw_t s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= m) begin
      s = s - m;
    end
    return s[WordBits-1:0];
  endfunction

endpackage

// ===== hw/rtl/tpsu_reduce.sv =====
`timescale 1ns / 1ps
module tpsu_reduce import tpsu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  modw_t modulus_i,
  input  logic  valid_i,
  input  red_t  item_i,
  output logic  valid_o,
  output red_t  item_o
);

  red_t st_d [WordBits];
  red_t st_q [WordBits];
  logic vld_q [WordBits];

  for (genvar k = 0; k < WordBits; k++) begin : g_stage
    red_t src;
    logic src_v;

    if (k == 0) begin : g_first
      assign src   = item_i;
      assign src_v = valid_i;
    end else begin : g_next
      assign src   = st_q[k-1];
      assign src_v = vld_q[k-1];
    end

    always_comb begin
      st_d[k] = src;
      for (int l = 0; l < NumLanes; l++) begin
        st_d[k].rem[l] = div_step(src.rem[l], src.raw[l][WordBits-1-k], modulus_i);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign valid_o = vld_q[WordBits-1];
  assign item_o  = st_q[WordBits-1];

endmodule

// ===== hw/rtl/tpsu_mulmod.sv =====
`timescale 1ns / 1ps
module tpsu_mulmod import tpsu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  modw_t modulus_i,
  input  logic  valid_i,
  input  mul_t  item_i,
  output logic  valid_o,
  output mul_t  item_o
);

  mul_t st_d [MulStages];
  mul_t st_q [MulStages];
  logic vld_q [MulStages];

  // even stage doubles, odd stage adds x when the multiplier bit is set
  for (genvar k = 0; k < MulStages; k++) begin : g_stage
    mul_t src;
    logic src_v;

    if (k == 0) begin : g_first
      assign src   = item_i;
      assign src_v = valid_i;
    end else begin : g_next
      assign src   = st_q[k-1];
      assign src_v = vld_q[k-1];
    end

    if (k % 2 == 0) begin : g_dbl
      always_comb begin
        st_d[k] = src;
        st_d[k].acc = mod_add(src.acc, src.acc, modulus_i);
      end
    end else begin : g_add
      always_comb begin
        st_d[k] = src;
        if (src.y[WordBits-1-k/2]) begin
          st_d[k].acc = mod_add(src.acc, src.x, modulus_i);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign valid_o = vld_q[MulStages-1];
  assign item_o  = st_q[MulStages-1];

endmodule

// ===== hw/rtl/transit_proof_share_update_unit.sv =====
`timescale 1ns / 1ps
// Proof-of-transit share update and check.
// Input channel: in_valid_i / in_stall_o with op_i, cumulative_in_i and
// packet_random_i. Output channel: out_valid_o / out_stall_i with
// cumulative_out_o and proof_ok_o. Exactly one result per item, in order.
// Configuration: APB-style port, 64-bit registers at byte address 8*i.
// The item enters the first of 196 registers at the accepting edge and
// passes 64 restoring division stages that reduce all operands modulo the
// prime, two modular add stages, 128 double-and-add stages for the modular
// multiply, a final add stage and the output register before out_valid_o.
// Throughput is one item per cycle while the skid register is empty.
// When the receiver stalls, the result holds on the outputs and one more
// item drains into a skid register; the pipeline then freezes and
// in_stall_o rises in the same cycle, so nothing is lost or repeated.
// Reset empties the pipeline and sets the prime to 2, all other configuration
// registers to 0. No clearing pass is needed.
module transit_proof_share_update_unit import tpsu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  word_t       cumulative_in_i,
  input  word_t       packet_random_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output word_t       cumulative_out_o,
  output logic        proof_ok_o
);

  word_t prime_q, share_q, lpc_q, poly_q, key_q;
  logic  upd_en_q, ver_en_q;
  logic  cfg_wr;
  reg_e  cfg_idx;
  modw_t modulus;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_e'(paddr[5:3]);
  assign modulus = (prime_q == '0) ? {1'b1, word_t'(0)} : {1'b0, prime_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q  <= word_t'(2);
      share_q  <= '0;
      lpc_q    <= '0;
      poly_q   <= '0;
      key_q    <= '0;
      upd_en_q <= 1'b0;
      ver_en_q <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegPrime:    prime_q  <= pwdata[WordBits-1:0];
        RegShare:    share_q  <= pwdata[WordBits-1:0];
        RegLagrange: lpc_q    <= pwdata[WordBits-1:0];
        RegPoly:     poly_q   <= pwdata[WordBits-1:0];
        RegKey:      key_q    <= pwdata[WordBits-1:0];
        RegUpdEn:    upd_en_q <= pwdata[0];
        RegVerEn:    ver_en_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegPrime:    prdata = prime_q;
      RegShare:    prdata = share_q;
      RegLagrange: prdata = lpc_q;
      RegPoly:     prdata = poly_q;
      RegKey:      prdata = key_q;
      RegUpdEn:    prdata = {63'd0, upd_en_q};
      RegVerEn:    prdata = {63'd0, ver_en_q};
      default:     prdata = '0;
    endcase
  end

  // pipeline moves while the skid register is empty
  logic en;
  logic skid_v_q, out_v_q;
  res_t skid_q, out_q;

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  red_t red_in, red_out;
  logic red_v;

  always_comb begin
    red_in.op             = op_e'(op_i);
    red_in.raw[LaneCum]   = cumulative_in_i;
    red_in.raw[LaneRnd]   = packet_random_i;
    red_in.raw[LanePoly]  = poly_q;
    red_in.raw[LaneShare] = share_q;
    red_in.raw[LaneLpc]   = lpc_q;
    red_in.raw[LaneKey]   = key_q;
    red_in.rem            = '0;
  end

  tpsu_reduce u_reduce (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .modulus_i (modulus),
    .valid_i   (in_valid_i),
    .item_i    (red_in),
    .valid_o   (red_v),
    .item_o    (red_out)
  );

  // first add stage: poly + random, and the verifier compare
  add_t  a1_d, a1_q;
  logic  a1_v_q;
  word_t vsum;
  word_t wsum;

  always_comb begin
    vsum     = mod_add(red_out.rem[LaneRnd], red_out.rem[LaneKey], modulus);
    wsum     = red_out.raw[LaneRnd] + red_out.raw[LaneKey];
    a1_d.op  = red_out.op;
    a1_d.ok  = (red_out.op == OpValidate) && ver_en_q &&
               ((red_out.raw[LaneCum] == wsum) || (red_out.raw[LaneCum] == vsum));
    a1_d.cum   = red_out.rem[LaneCum];
    a1_d.t     = mod_add(red_out.rem[LanePoly], red_out.rem[LaneRnd], modulus);
    a1_d.share = red_out.rem[LaneShare];
    a1_d.lpc   = red_out.rem[LaneLpc];
  end

  // second add stage: + share
  mul_t a2_d, a2_q;
  logic a2_v_q;

  always_comb begin
    a2_d.op  = a1_q.op;
    a2_d.ok  = a1_q.ok;
    a2_d.cum = a1_q.cum;
    a2_d.x   = mod_add(a1_q.t, a1_q.share, modulus);
    a2_d.y   = a1_q.lpc;
    a2_d.acc = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_v_q <= 1'b0;
      a2_v_q <= 1'b0;
    end else if (en) begin
      a1_v_q <= red_v;
      a2_v_q <= a1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q <= a1_d;
      a2_q <= a2_d;
    end
  end

  mul_t mul_out;
  logic mul_v;

  tpsu_mulmod u_mulmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .modulus_i (modulus),
    .valid_i   (a2_v_q),
    .item_i    (a2_q),
    .valid_o   (mul_v),
    .item_o    (mul_out)
  );

  // final add: cumulative + product
  res_t fin_d, fin_q;
  logic fin_v_q;

  always_comb begin
    fin_d.ok  = mul_out.ok;
    fin_d.cum = ((mul_out.op == OpUpdate) && upd_en_q) ?
                mod_add(mul_out.cum, mul_out.acc, modulus) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q <= 1'b0;
    end else if (en) begin
      fin_v_q <= mul_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_q <= fin_d;
    end
  end

  // output register with skid
  logic push, take;

  assign push = fin_v_q && en;
  assign take = out_v_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (take || !out_v_q) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= push;
      end else begin
        out_v_q  <= push;
      end
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take || !out_v_q) begin
      if (skid_v_q) begin
        out_q <= skid_q;
        if (push) begin
          skid_q <= fin_q;
        end
      end else if (push) begin
        out_q <= fin_q;
      end
    end else if (push) begin
      skid_q <= fin_q;
    end
  end

  assign out_valid_o      = out_v_q;
  assign cumulative_out_o = out_q.cum;
  assign proof_ok_o       = out_q.ok;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds an item while output register is empty");

  a_stalled_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_stall_i) |=> out_v_q)
    else $error("stalled result dropped");

  a_fields_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.ok) |-> (out_q.cum == '0))
    else $error("proof_ok set together with nonzero cumulative");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |=> $stable(fin_v_q))
    else $error("pipeline moved while skid was full");

endmodule
